FILE: rtl/stream_find_and_replace_defines.svh
// assertion macros shared by the checker of the find-and-replace block
`ifndef STREAM_FIND_AND_REPLACE_DEFINES_SVH
`define STREAM_FIND_AND_REPLACE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr assertion failed");

// next-cycle implication, disabled in reset
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

`endif

FILE: rtl/sfr_pkg.sv
// shared types and constants of the find-and-replace block
package sfr_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes of the write port
    localparam cfg_idx_t REG_PATTERN_LEN       = 2'd0;
    localparam cfg_idx_t REG_PATTERN_BYTES     = 2'd1;
    localparam cfg_idx_t REG_REPLACEMENT_LEN   = 2'd2;
    localparam cfg_idx_t REG_REPLACEMENT_BYTES = 2'd3;

    localparam logic [3:0] REPL_MAX = 4'd8;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
        logic active;
    } cell_ctrl_t;

endpackage

FILE: rtl/sfr_stream_if.sv
// stream channels of the find-and-replace block
interface sfr_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_string;

    modport source (output valid, output in_byte, output byte_present,
                    output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input byte_present,
                    input end_of_string, output ready);
endinterface

interface sfr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_present;
    logic       out_last;

    modport source (output valid, output out_byte, output out_present,
                    output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_present,
                    input out_last, output ready);
endinterface

FILE: rtl/sfr_cell.sv
// one window cell: holds a pending byte and checks it against its pattern byte
module sfr_cell
(
    input  logic               clk,
    input  sfr_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]         load_byte,
    input  logic [7:0]         next_byte,
    input  logic [7:0]         pat_byte,
    input  logic               ok_in,
    output logic [7:0]         held_byte,
    output logic               ok_out
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            byte_reg <= load_byte;
        end
        else if (ctrl.shift)
        begin
            byte_reg <= next_byte;
        end
    end

    assign held_byte = byte_reg;
    // prefix chain: inactive cells pass the verdict through
    assign ok_out    = ok_in & (~ctrl.active | (byte_reg == pat_byte));

endmodule

FILE: rtl/stream_find_and_replace.sv
// top level of the streaming find-and-replace block
// flow: a beat is accepted in idle and checked in S_CHECK, then its results leave
//   through a registered output stage
// throughput: one result per cycle while the output is not stalled; a new beat is
//   taken only when the item before it is done
// reset: sequencer, held count and output valid cleared, registers to their reset values
module stream_find_and_replace
#(
    parameter int MAX_PATTERN = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  sfr_pkg::cfg_idx_t             wr_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] wr_data,
    sfr_text_if.sink                      text,
    sfr_result_if.source                  rewritten
);

    // count width: must hold MAX_PATTERN itself
    localparam int CW = $clog2(MAX_PATTERN + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_REPL,
        S_DROP,
        S_FLUSH,
        S_MARK
    } state_t;

    // configuration registers
    logic [3:0]  plen_reg;
    logic [63:0] pattern_reg;
    logic [3:0]  rlen_reg;
    logic [63:0] repl_reg;

    // sequencer state
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          end_reg, end_next;
    logic          added_reg, added_next;
    logic [2:0]    ridx_reg, ridx_next;

    // output stage
    logic       ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic       op_reg, op_next;
    logic       ol_reg, ol_next;

    logic [CW-1:0] plen_eff;
    logic [3:0]    rlen_eff;
    logic          can_emit;
    logic          accept;
    logic          shift_en;
    logic          prefix_ok;
    logic [7:0]    head_byte;

    logic [7:0]    cell_byte [MAX_PATTERN];
    logic [MAX_PATTERN:0] ok_chain;

    // pattern length as the logic sees it: zero reads as one, the top clips
    function automatic logic [CW-1:0] clamp_plen(input logic [3:0] v);
        logic [CW-1:0] r;
        if (v == 4'd0)
        begin
            r = CW'(1);
        end
        else if (32'(v) > MAX_PATTERN)
        begin
            r = CW'(MAX_PATTERN);
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    assign plen_eff = clamp_plen(plen_reg);
    assign rlen_eff = (rlen_reg > sfr_pkg::REPL_MAX) ? sfr_pkg::REPL_MAX : rlen_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg    <= 4'd1;
            pattern_reg <= '0;
            rlen_reg    <= 4'd0;
            repl_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                sfr_pkg::REG_PATTERN_LEN:       plen_reg    <= wr_data[3:0];
                sfr_pkg::REG_PATTERN_BYTES:     pattern_reg <= wr_data;
                sfr_pkg::REG_REPLACEMENT_LEN:   rlen_reg    <= wr_data[3:0];
                sfr_pkg::REG_REPLACEMENT_BYTES: repl_reg    <= wr_data;
                default:                        ;
            endcase
        end
    end

    // row of window cells, oldest byte in cell 0, shifting towards cell 0
    assign ok_chain[0] = 1'b1;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        sfr_pkg::cell_ctrl_t ctrl;
        logic [7:0]          nb;

        assign ctrl.load   = accept && text.byte_present &&
                             (count_reg < CW'(MAX_PATTERN)) && (count_reg == CW'(i));
        assign ctrl.shift  = shift_en;
        assign ctrl.active = (CW'(i) < count_reg);

        if (i == MAX_PATTERN - 1)
        begin : g_tail
            assign nb = 8'h00;
        end
        else
        begin : g_body
            assign nb = cell_byte[i+1];
        end

        sfr_cell u_cell
        (
            .clk       (clk),
            .ctrl      (ctrl),
            .load_byte (text.in_byte),
            .next_byte (nb),
            .pat_byte  (pattern_reg[i*8 +: 8]),
            .ok_in     (ok_chain[i]),
            .held_byte (cell_byte[i]),
            .ok_out    (ok_chain[i+1])
        );
    end

    // held bytes still form a prefix of the pattern
    assign prefix_ok = ok_chain[MAX_PATTERN];
    assign head_byte = cell_byte[0];

    assign text.ready = (state_reg == S_IDLE);
    assign accept     = text.valid && text.ready;
    // output slot free this cycle or freed by the consumer taking the beat
    assign can_emit   = !ov_reg || rewritten.ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        end_next   = end_reg;
        added_next = added_reg;
        ridx_next  = ridx_reg;
        ov_next    = ov_reg && !rewritten.ready;
        ob_next    = ob_reg;
        op_next    = op_reg;
        ol_next    = ol_reg;
        shift_en   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    added_next = text.byte_present && (count_reg < CW'(MAX_PATTERN));
                    end_next   = text.end_of_string;
                    if (text.byte_present && (count_reg < CW'(MAX_PATTERN)))
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    state_next = S_CHECK;
                end
                else if (wr_en && (wr_index == sfr_pkg::REG_PATTERN_LEN) &&
                         (count_reg >= clamp_plen(wr_data[3:0])))
                begin
                    // pattern length set to no more than what is held: drop the held bytes
                    count_next = '0;
                end
            end

            S_CHECK:
            begin
                if (added_reg && (count_reg == plen_eff) && prefix_ok)
                begin
                    // full match: held bytes replaced
                    count_next = '0;
                    ridx_next  = 3'd0;
                    if (rlen_eff != 4'd0)
                    begin
                        state_next = S_REPL;
                    end
                    else if (end_reg)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (end_reg)
                begin
                    // at the end every held byte goes out in order
                    state_next = (count_reg != '0) ? S_FLUSH : S_MARK;
                end
                else if (added_reg && (count_reg != '0) && !prefix_ok)
                begin
                    // only a new byte releases held ones; a beat with no byte leaves them
                    state_next = S_DROP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_REPL:
            begin
                if (can_emit)
                begin
                    ov_next = 1'b1;
                    ob_next = repl_reg[ridx_reg*8 +: 8];
                    op_next = 1'b1;
                    ol_next = end_reg && ({1'b0, ridx_reg} == (rlen_eff - 4'd1));
                    if ({1'b0, ridx_reg} == (rlen_eff - 4'd1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ridx_next = ridx_reg + 3'd1;
                    end
                end
            end

            S_DROP:
            begin
                if ((count_reg != '0) && !prefix_ok)
                begin
                    // release the oldest byte until the rest is a prefix again
                    if (can_emit)
                    begin
                        ov_next    = 1'b1;
                        ob_next    = head_byte;
                        op_next    = 1'b1;
                        ol_next    = 1'b0;
                        shift_en   = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_FLUSH:
            begin
                if (can_emit)
                begin
                    ov_next    = 1'b1;
                    ob_next    = head_byte;
                    op_next    = 1'b1;
                    ol_next    = (count_reg == CW'(1));
                    shift_en   = 1'b1;
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_MARK:
            begin
                // end beat with no byte result: bare end marker
                if (can_emit)
                begin
                    ov_next    = 1'b1;
                    ob_next    = 8'h00;
                    op_next    = 1'b0;
                    ol_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            end_reg   <= 1'b0;
            added_reg <= 1'b0;
            ridx_reg  <= 3'd0;
            ov_reg    <= 1'b0;
            ob_reg    <= 8'h00;
            op_reg    <= 1'b0;
            ol_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            end_reg   <= end_next;
            added_reg <= added_next;
            ridx_reg  <= ridx_next;
            ov_reg    <= ov_next;
            ob_reg    <= ob_next;
            op_reg    <= op_next;
            ol_reg    <= ol_next;
        end
    end

    assign rewritten.valid       = ov_reg;
    assign rewritten.out_byte    = ob_reg;
    assign rewritten.out_present = op_reg;
    assign rewritten.out_last    = ol_reg;

endmodule

FILE: rtl/sfr_checker.sv
// port-level checker of the find-and-replace block and its bind
`include "stream_find_and_replace_defines.svh"

module sfr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_present,
    input logic       out_last
);

    // a stalled result beat stays offered
    `SFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // and keeps its payload
    `SFR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_byte) && $stable(out_present) && $stable(out_last))
    // a bare marker only ever closes a string and carries a zero byte
    `SFR_ASSERT_NOW(a_bare_marker, clk, rst_n, out_valid && !out_present, out_last && (out_byte == 8'h00))
    // one beat at a time: no new beat in the cycle after one is taken
    `SFR_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (text.valid),
    .in_ready    (text.ready),
    .out_valid   (rewritten.valid),
    .out_ready   (rewritten.ready),
    .out_byte    (rewritten.out_byte),
    .out_present (rewritten.out_present),
    .out_last    (rewritten.out_last)
);
